// ----- design/sfd_pkg.sv -----
// Shared constants, codes and types of the S/PDIF subframe decoder.
package sfd_pkg;

  localparam int IntervalBits = 16;
  localparam int SDataW       = ((IntervalBits + 7) / 8) * 8;
  localparam int CfgW         = 16;
  localparam int CfgIdxW      = 2;
  localparam int AudioBits    = 24;
  localparam int Slots        = 28;
  localparam int StatusSlot   = 26;
  localparam int SlotW        = 5;
  localparam int MDataW       = 32;
  localparam int KindW        = 2;
  localparam int CmpW         = ((IntervalBits > CfgW) ? IntervalBits : CfgW) + 1;

  // tdata bit positions of the result fields
  localparam int CsbPos  = AudioBits;
  localparam int FerrPos = AudioBits + 1;
  localparam int PerrPos = AudioBits + 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOneCell   = 2'd0,
    CfgTwoCell   = 2'd1,
    CfgThreeCell = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhDiscard  = 3'd0,
    PhHunt     = 3'd1,
    PhStart    = 3'd2,
    PhPreamble = 3'd3,
    PhData     = 3'd4
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KindB   = 2'd0,
    KindM   = 2'd1,
    KindW_  = 2'd2,
    KindBad = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e                 phase;
    logic [1:0]             pre_step;
    logic [SlotW-1:0]       slot;
    logic                   half;
    logic [AudioBits-1:0]   data;
    logic                   parity;
    logic                   status;
    kind_e                  kind;
    logic                   ferr;
  } dec_state_t;

  localparam dec_state_t StateReset = '{PhDiscard, 2'd0, 5'd0, 1'b0, 24'd0,
                                        1'b0, 1'b0, KindB, 1'b0};

  typedef struct packed {
    logic [AudioBits-1:0] audio_word;
    logic                 channel_status_bit;
    kind_e                preamble_kind;
    logic                 framing_error;
    logic                 parity_error;
  } subframe_t;

  typedef struct packed {
    dec_state_t st;
    logic       emit;
    subframe_t  sf;
  } step_t;

  // interval classification against the three thresholds
  typedef struct packed {
    logic gt_one_max;
    logic lt_two;
    logic gt_two_max;
    logic lt_three;
    logic gt_three_max;
  } cmp_t;

endpackage

// ----- design/spdif_subframe_decoder_core.sv -----
// S/PDIF biphase-mark subframe decoder: edge intervals in, decoded subframes out.
//
//  channel   | dir | payload                                   | transaction when
//  s_axis    | in  | tdata[15:0] interval_len                  | tvalid & tready
//  m_axis    | out | tdata audio/status/errors, tuser kind     | tvalid & tready
//  cfg       | in  | cfg_idx_i selects threshold, cfg_wdata_i  | cfg_we_i
//
// One interval per cycle sustained while no result is held back. An interval
// is held in the input register, then the single-pass decode step updates the
// frame state and loads the result register that drives m_axis_tvalid_o, so
// a result transaction follows its interval through these two registers.
// The input stage stalls only when a result is due while the output register
// is full and m_axis_tready_i is low. Reset is asynchronous, active low; the
// first interval after reset is dropped, then the decoder hunts for a preamble.
module spdif_subframe_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [15:0] interval_len
  input  logic [sfd_pkg::SDataW-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [23:0] audio_word, [24] channel_status_bit, [25] framing_error,
  // [26] parity_error, [31:27] zero
  output logic [sfd_pkg::MDataW-1:0]  m_axis_tdata_o,
  // [1:0] preamble_kind
  output logic [sfd_pkg::KindW-1:0]   m_axis_tuser_o,
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfd_pkg::CfgW-1:0]    cfg_wdata_i
);
  import sfd_pkg::*;

  logic [CfgW-1:0]         one_min_q, two_min_q, three_min_q;
  logic                    in_valid_q;
  logic [IntervalBits-1:0] in_len_q;
  dec_state_t              state_q;
  logic                    out_valid_q;
  subframe_t               out_q;

  logic [CmpW-1:0] len_x, one_max_x, two_min_x, two_max_x, three_min_x, three_max_x;
  cmp_t            cmp;
  step_t           step;
  logic            advance;

  function automatic dec_state_t start_frame(dec_state_t s);
    dec_state_t r;
    r          = s;
    r.phase    = PhPreamble;
    r.pre_step = 2'd0;
    r.slot     = '0;
    r.half     = 1'b0;
    r.data     = '0;
    r.parity   = 1'b0;
    r.status   = 1'b0;
    r.kind     = KindBad;
    r.ferr     = 1'b0;
    return r;
  endfunction

  // first pulse of the next subframe, or back to hunting if it is too long
  function automatic dec_state_t restart(dec_state_t s, logic too_long);
    dec_state_t r;
    r = s;
    if (too_long) begin
      r.phase = PhHunt;
    end else begin
      r = start_frame(s);
    end
    return r;
  endfunction

  function automatic step_t finish_slot(dec_state_t s, logic bit_v, logic ok);
    step_t            r;
    logic             b;
    logic [SlotW-1:0] nxt;
    r.st   = s;
    r.emit = 1'b0;
    r.sf   = '0;
    b      = bit_v & ok;
    nxt    = s.slot + 1'b1;
    if (!ok) r.st.ferr = 1'b1;
    if (s.slot < SlotW'(AudioBits)) r.st.data = {b, s.data[AudioBits-1:1]};
    if (s.slot < SlotW'(Slots - 1)) r.st.parity = s.parity ^ b;
    if (s.slot == SlotW'(StatusSlot)) r.st.status = b;
    r.st.slot = nxt;
    if (nxt >= SlotW'(Slots)) begin
      r.emit                  = 1'b1;
      r.sf.audio_word         = r.st.data;
      r.sf.channel_status_bit = r.st.status;
      r.sf.preamble_kind      = s.kind;
      r.sf.framing_error      = r.st.ferr;
      r.sf.parity_error       = ok & (s.parity ^ b);
      r.st.phase              = PhStart;
      r.st.half               = 1'b0;
    end
    return r;
  endfunction

  // every remaining slot counts as a bad zero
  function automatic step_t fill_rest(dec_state_t s);
    step_t r;
    r.st      = s;
    r.emit    = 1'b1;
    r.sf      = '0;
    if (s.slot < SlotW'(AudioBits)) begin
      r.st.data = s.data >> (SlotW'(AudioBits) - s.slot);
    end
    if (s.slot <= SlotW'(StatusSlot)) r.st.status = 1'b0;
    r.st.ferr  = 1'b1;
    r.st.slot  = SlotW'(Slots);
    r.st.phase = PhStart;
    r.st.half  = 1'b0;
    r.sf.audio_word         = r.st.data;
    r.sf.channel_status_bit = r.st.status;
    r.sf.preamble_kind      = s.kind;
    r.sf.framing_error      = 1'b1;
    r.sf.parity_error       = 1'b0;
    return r;
  endfunction

  // slot interval with no half of a one pending
  function automatic step_t take_slot(dec_state_t s, cmp_t c);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.sf   = '0;
    if (c.gt_two_max) begin
      r      = fill_rest(s);
      r.st   = restart(r.st, c.gt_three_max);
    end else if (!c.lt_two) begin
      r = finish_slot(s, 1'b0, 1'b1);
    end else begin
      r.st.half = 1'b1;
    end
    return r;
  endfunction

  assign len_x       = CmpW'(in_len_q);
  assign one_max_x   = CmpW'(one_min_q) + CmpW'(2);
  assign two_min_x   = CmpW'(two_min_q);
  assign two_max_x   = CmpW'(two_min_q) + CmpW'(2);
  assign three_min_x = CmpW'(three_min_q);
  assign three_max_x = CmpW'(three_min_q) + CmpW'(2);

  always_comb begin
    cmp.gt_one_max   = len_x > one_max_x;
    cmp.lt_two       = len_x < two_min_x;
    cmp.gt_two_max   = len_x > two_max_x;
    cmp.lt_three     = len_x < three_min_x;
    cmp.gt_three_max = len_x > three_max_x;
  end

  // decode step for the interval in the input register
  always_comb begin
    dec_state_t s1;
    step_t      r2;
    step.st   = state_q;
    step.emit = 1'b0;
    step.sf   = '0;
    s1        = state_q;
    r2        = '0;
    unique case (state_q.phase)
      PhHunt: begin
        if (!cmp.lt_three && !cmp.gt_three_max) step.st = start_frame(state_q);
      end
      PhStart: begin
        step.st = restart(state_q, cmp.gt_three_max);
      end
      PhPreamble: begin
        if (state_q.pre_step == 2'd0) begin
          if (cmp.gt_three_max) begin
            step.st.kind  = KindBad;
            step.st.ferr  = 1'b1;
            step.st.phase = PhData;
          end else begin
            if (!cmp.lt_three) step.st.kind = KindM;
            else if (!cmp.lt_two) step.st.kind = KindW_;
            else step.st.kind = KindB;
            step.st.pre_step = 2'd1;
          end
        end else if (state_q.pre_step == 2'd1) begin
          if (cmp.gt_one_max) step.st.ferr = 1'b1;
          step.st.pre_step = 2'd2;
        end else begin
          // last preamble pulse: length depends on the kind
          case (state_q.kind)
            KindM:   s1.ferr = cmp.gt_one_max;
            KindW_:  s1.ferr = cmp.gt_two_max | cmp.lt_two;
            default: s1.ferr = cmp.gt_three_max | cmp.lt_three;
          endcase
          if (s1.ferr) step.st.ferr = 1'b1;
          step.st.phase = PhData;
        end
      end
      PhData: begin
        if (state_q.half) begin
          s1.half = 1'b0;
          if (cmp.lt_two) begin
            step = finish_slot(s1, 1'b1, 1'b1);
          end else begin
            // broken one: bad slot, then the same interval starts over
            step = finish_slot(s1, 1'b0, 1'b0);
            if (step.emit) begin
              step.st = restart(step.st, cmp.gt_three_max);
            end else begin
              r2      = take_slot(step.st, cmp);
              step.st = r2.st;
              if (r2.emit) begin
                step.emit = 1'b1;
                step.sf   = r2.sf;
              end
            end
          end
        end else begin
          step = take_slot(state_q, cmp);
        end
      end
      default: step.st.phase = PhHunt;
    endcase
  end

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i | ~step.emit);
  assign s_axis_tready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_min_q   <= CfgW'(3);
      two_min_q   <= CfgW'(7);
      three_min_q <= CfgW'(11);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgOneCell:   one_min_q   <= cfg_wdata_i;
        CfgTwoCell:   two_min_q   <= cfg_wdata_i;
        CfgThreeCell: three_min_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) state_q <= step.st;
      if (advance && step.emit) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_len_q <= s_axis_tdata_i[IntervalBits-1:0];
    if (advance && step.emit) out_q <= step.sf;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(MDataW - AudioBits - 3)'(0), out_q.parity_error,
                            out_q.framing_error, out_q.channel_status_bit,
                            out_q.audio_word};
  assign m_axis_tuser_o  = out_q.preamble_kind;

endmodule

// ----- design/sfd_checker.sv -----
// Port-level checks for the S/PDIF subframe decoder, bound to the top level.
module sfd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [sfd_pkg::MDataW-1:0]  m_axis_tdata_o,
  input logic [sfd_pkg::KindW-1:0]   m_axis_tuser_o
);
  import sfd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // no result shows while reset is applied
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // an unrecognized preamble always carries a framing error
  a_bad_kind_ferr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KindBad |-> m_axis_tdata_o[FerrPos])
    else $error("unrecognized preamble without framing error");

  // input never stalls while the output side drains
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled with output ready");

endmodule

bind spdif_subframe_decoder_core sfd_checker u_sfd_checker (.*);

// ----- tb/spdif_subframe_decoder_checker.sv -----
`timescale 1ns / 1ps
// Subframe predictor and output comparison for the S/PDIF subframe decoder.
module spdif_subframe_decoder_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [sfd_pkg::SDataW-1:0]  s_tdata_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [sfd_pkg::MDataW-1:0]  m_tdata_i,
  input  logic [sfd_pkg::KindW-1:0]   m_tuser_i,
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfd_pkg::CfgW-1:0]    cfg_wdata_i,
  output int                          mismatches_o,
  output int                          subframes_due_o,
  output int                          subframes_seen_o
);
  import sfd_pkg::*;

  // thresholds as last written
  logic [CfgW-1:0]      lo_one, lo_two, lo_three;

  // decoder state as predicted
  phase_e               dec_phase;
  logic [1:0]           pre_idx;
  int                   slots_done;
  logic                 half_seen;
  logic [AudioBits-1:0] audio_sr;
  logic                 parity_acc;
  logic                 status_acc;
  logic                 ferr_acc;
  kind_e                kind_acc;

  logic                 got_subframe;
  subframe_t            next_subframe;
  subframe_t            subframes_due[$];
  int                   mismatches = 0;
  int                   seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: subframe %0d %s: got %h, expected %h", $time, seen, what, got, want);
  endtask

  task automatic open_subframe();
    dec_phase  = PhPreamble;
    pre_idx    = 2'd0;
    slots_done = 0;
    half_seen  = 1'b0;
    audio_sr   = '0;
    parity_acc = 1'b0;
    status_acc = 1'b0;
    kind_acc   = KindBad;
    ferr_acc   = 1'b0;
  endtask

  // a bad slot contributes a zero everywhere and flags framing
  task automatic close_slot(input logic value, input logic ok);
    logic b;
    logic perr;
    b    = value & ok;
    perr = 1'b0;
    if (!ok) ferr_acc = 1'b1;
    if (slots_done < AudioBits) audio_sr = {b, audio_sr[AudioBits-1:1]};
    if (slots_done < Slots - 1) parity_acc ^= b;
    if (slots_done == StatusSlot) status_acc = b;
    if (slots_done == Slots - 1 && ok) perr = parity_acc ^ b;
    slots_done++;
    if (slots_done >= Slots) begin
      got_subframe                     = 1'b1;
      next_subframe.audio_word         = audio_sr;
      next_subframe.channel_status_bit = status_acc;
      next_subframe.preamble_kind      = kind_acc;
      next_subframe.framing_error      = ferr_acc;
      next_subframe.parity_error       = perr;
      dec_phase                        = PhStart;
      half_seen                        = 1'b0;
    end
  endtask

  // used comes back low when the interval must be decoded again
  task automatic decode_slot(input logic [15:0] len, output logic used);
    logic [16:0] two_max;
    two_max = {1'b0, lo_two} + 17'd2;
    used    = 1'b1;
    if (half_seen) begin
      half_seen = 1'b0;
      if (len < lo_two) begin
        close_slot(1'b1, 1'b1);
      end else begin
        close_slot(1'b0, 1'b0);
        used = 1'b0;
      end
    end else if (len > two_max) begin
      while (dec_phase == PhData) close_slot(1'b0, 1'b0);
      used = 1'b0;
    end else if (len >= lo_two) begin
      close_slot(1'b0, 1'b1);
    end else begin
      half_seen = 1'b1;
    end
  endtask

  task automatic decode_preamble(input logic [15:0] len);
    logic [16:0] one_max, two_max, three_max;
    logic        bad;
    one_max   = {1'b0, lo_one} + 17'd2;
    two_max   = {1'b0, lo_two} + 17'd2;
    three_max = {1'b0, lo_three} + 17'd2;
    case (pre_idx)
      2'd0: begin
        if (len > three_max) begin
          kind_acc  = KindBad;
          ferr_acc  = 1'b1;
          dec_phase = PhData;
        end else begin
          if (len >= lo_three) kind_acc = KindM;
          else if (len >= lo_two) kind_acc = KindW_;
          else kind_acc = KindB;
          pre_idx = 2'd1;
        end
      end
      2'd1: begin
        if (len > one_max) ferr_acc = 1'b1;
        pre_idx = 2'd2;
      end
      default: begin
        if (kind_acc == KindM) bad = len > one_max;
        else if (kind_acc == KindW_) bad = len > two_max || len < lo_two;
        else bad = len > three_max || len < lo_three;
        if (bad) ferr_acc = 1'b1;
        dec_phase = PhData;
      end
    endcase
  endtask

  task automatic decode_interval(input logic [15:0] len);
    logic        used;
    int          guard;
    logic [16:0] three_max;
    three_max    = {1'b0, lo_three} + 17'd2;
    got_subframe = 1'b0;
    used         = 1'b0;
    guard        = 0;
    while (!used && guard < 6) begin
      guard++;
      case (dec_phase)
        PhHunt: begin
          if (len >= lo_three && len <= three_max) open_subframe();
          used = 1'b1;
        end
        PhStart: begin
          if (len > three_max) dec_phase = PhHunt;
          else open_subframe();
          used = 1'b1;
        end
        PhPreamble: begin
          decode_preamble(len);
          used = 1'b1;
        end
        PhData: decode_slot(len, used);
        default: begin
          dec_phase = PhHunt;
          used      = 1'b1;
        end
      endcase
    end
  endtask

  task automatic check_subframe();
    subframe_t want;
    if (subframes_due.size() == 0) begin
      report_mismatch("arrived with none due", m_tdata_i, '0);
    end else begin
      want = subframes_due.pop_front();
      if (m_tdata_i[AudioBits-1:0] != want.audio_word)
        report_mismatch("audio_word", m_tdata_i[AudioBits-1:0], want.audio_word);
      if (m_tdata_i[CsbPos] != want.channel_status_bit)
        report_mismatch("channel_status_bit", m_tdata_i[CsbPos], want.channel_status_bit);
      if (m_tdata_i[FerrPos] != want.framing_error)
        report_mismatch("framing_error", m_tdata_i[FerrPos], want.framing_error);
      if (m_tdata_i[PerrPos] != want.parity_error)
        report_mismatch("parity_error", m_tdata_i[PerrPos], want.parity_error);
      if (m_tdata_i[MDataW-1:PerrPos+1] != '0)
        report_mismatch("tdata padding", m_tdata_i, '0);
      if (m_tuser_i != want.preamble_kind)
        report_mismatch("preamble_kind", m_tuser_i, want.preamble_kind);
    end
    seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_one     = 16'd3;
      lo_two     = 16'd7;
      lo_three   = 16'd11;
      dec_phase  = PhDiscard;
      pre_idx    = 2'd0;
      slots_done = 0;
      half_seen  = 1'b0;
      audio_sr   = '0;
      parity_acc = 1'b0;
      status_acc = 1'b0;
      kind_acc   = KindB;
      ferr_acc   = 1'b0;
      subframes_due.delete();
      mismatches_o     <= 0;
      subframes_due_o  <= 0;
      subframes_seen_o <= 0;
    end else begin
      // compare before predicting so a stray result cannot match a fresh expectation
      if (m_tvalid_i && m_tready_i) check_subframe();
      if (s_tvalid_i && s_tready_i) begin
        decode_interval(s_tdata_i[IntervalBits-1:0]);
        if (got_subframe) subframes_due.push_back(next_subframe);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgOneCell:   lo_one   = cfg_wdata_i;
          CfgTwoCell:   lo_two   = cfg_wdata_i;
          CfgThreeCell: lo_three = cfg_wdata_i;
          default: ;
        endcase
      end
      mismatches_o     <= mismatches;
      subframes_due_o  <= subframes_due.size();
      subframes_seen_o <= seen;
    end
  end

endmodule

// ----- tb/tb_spdif_subframe_decoder_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the S/PDIF subframe decoder: stimulus, receiver pacing and verdict.
module tb_spdif_subframe_decoder_core;
  import sfd_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [SDataW-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [MDataW-1:0]    m_tdata;
  logic [KindW-1:0]     m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = CfgOneCell;
  logic [CfgW-1:0]      cfg_wdata = '0;

  int mismatches;
  int subframes_due;
  int subframes_seen;

  // thresholds currently loaded, used to shape intervals
  int thr_one = 3;
  int thr_two = 7;
  int thr_three = 11;

  int n_sent = 0;
  int n_settings = 1;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int cycle_cnt = 0;

  // hunt edge cases, B frame with a broken one and a too-long slot,
  // unrecognized preamble, M frame cut short
  logic [15:0] edge_probe[$] = '{16'd65535, 16'd0, 16'd10, 16'd14,
                                 16'd12, 16'd2, 16'd4, 16'd13,
                                 16'd3, 16'd5, 16'd7, 16'd9, 16'd4, 16'd9, 16'd14,
                                 16'd11, 16'd65535, 16'd0, 16'd65535,
                                 16'd11, 16'd13, 16'd5, 16'd0, 16'd15};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spdif_subframe_decoder_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  spdif_subframe_decoder_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatches_o     (mismatches),
    .subframes_due_o  (subframes_due),
    .subframes_seen_o (subframes_seen)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d subframes still due", cycle_cnt, subframes_due);
      $display("tb_spdif_subframe_decoder_core: done, errors");
      $finish;
    end
  end

  // receiver: stretches of always-ready, coin-flip and mostly-stalled, plus long hold-offs
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(2, 0);
          left = $urandom_range(80, 20);
        end
        left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(1, 0));
          default: m_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // one transaction on the input side; valid stays high inside a burst
  task automatic put_interval(input logic [15:0] len);
    s_tdata  <= len;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? 60 : $urandom_range(16, 1);
      if (!no_gaps) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [15:0] cell_len(input int cells);
    int lo;
    case (cells)
      1:       lo = thr_one;
      2:       lo = thr_two;
      default: lo = thr_three;
    endcase
    return 16'(lo + $urandom_range(2, 0));
  endfunction

  // longer than the two-cell and three-cell bounds where the thresholds allow it
  function automatic logic [15:0] far_len();
    int hi;
    hi = ((thr_two > thr_three) ? thr_two : thr_three) + 3;
    if (hi > 65535) hi = 65535;
    return 16'(hi);
  endfunction

  task automatic send_subframe();
    logic [15:0] seq[$];
    int          fill;
    int          s;
    int          pos;
    logic        b;
    logic        par;
    seq.push_back(cell_len(3));
    case ($urandom_range(2, 0))
      0: begin
        seq.push_back(cell_len(1));
        seq.push_back(cell_len(1));
        seq.push_back(cell_len(3));
      end
      1: begin
        seq.push_back(cell_len(3));
        seq.push_back(cell_len(1));
        seq.push_back(cell_len(1));
      end
      default: begin
        seq.push_back(cell_len(2));
        seq.push_back(cell_len(1));
        seq.push_back(cell_len(2));
      end
    endcase
    fill = $urandom_range(3, 0);
    par  = 1'b0;
    for (s = 0; s < Slots; s++) begin
      if (s == Slots - 1) b = par ^ ($urandom_range(5, 0) == 0);
      else if (fill == 0) b = 1'b0;
      else if (fill == 1) b = 1'b1;
      else b = 1'($urandom_range(1, 0));
      par ^= b;
      if (b) begin
        seq.push_back(cell_len(1));
        seq.push_back(cell_len(1));
      end else begin
        seq.push_back(cell_len(2));
      end
    end
    // damage one interval in about a quarter of the subframes
    if ($urandom_range(3, 0) == 0) begin
      pos = $urandom_range(seq.size() - 1, 0);
      case ($urandom_range(4, 0))
        0:       seq[pos] = 16'($urandom_range(65535, 0));
        1:       seq[pos] = '0;
        2:       seq[pos] = far_len();
        3:       seq[pos] = cell_len($urandom_range(3, 1));
        default: seq.delete(pos);
      endcase
    end
    foreach (seq[i]) put_interval(seq[i]);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1)) put_interval(16'($urandom_range(65535, 0)));
    if ($urandom_range(1, 0)) begin
      put_interval(far_len());
      put_interval(far_len());
    end
  endtask

  task automatic run_traffic(input int n_items);
    int stop_at;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(7, 0) == 0) send_noise();
      send_subframe();
    end
  endtask

  // receiver stalls while the sender keeps going until the decoder backs up
  task automatic hold_receiver();
    hold_requests++;
    no_gaps = 1'b1;
    repeat (3) send_subframe();
    no_gaps = 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (subframes_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_thresholds(input int one, input int two, input int three);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgOneCell;
    cfg_wdata <= one[CfgW-1:0];
    @(posedge clk);
    cfg_idx   <= CfgTwoCell;
    cfg_wdata <= two[CfgW-1:0];
    @(posedge clk);
    cfg_idx   <= CfgThreeCell;
    cfg_wdata <= three[CfgW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_one   = one;
    thr_two   = two;
    thr_three = three;
    n_settings++;
  endtask

  initial begin
    int c;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_probe[i]) put_interval(edge_probe[i]);
    run_traffic(200);

    drain();
    load_thresholds(2, 5, 8);
    run_traffic(200);

    drain();
    load_thresholds(0, 0, 0);
    run_traffic(200);

    drain();
    load_thresholds(65533, 65533, 65533);
    run_traffic(150);

    // thresholds out of order
    drain();
    load_thresholds(20, 5, 12);
    run_traffic(150);

    drain();
    load_thresholds(199, 399, 599);
    hold_receiver();
    run_traffic(100);

    drain();
    c = $urandom_range(60, 3);
    load_thresholds(c - 1, 2 * c - 1, 3 * c - 1);
    hold_receiver();
    run_traffic(100);

    drain();
    load_thresholds(3, 7, 11);
    run_traffic(250);

    drain();
    $display("covered %0d intervals and %0d subframes over %0d threshold settings",
             n_sent, subframes_seen, n_settings);
    $display("with %0d long receiver hold-offs; %0d field mismatches", holds_done, mismatches);
    if (mismatches == 0) begin
      $display("tb_spdif_subframe_decoder_core: done, clean");
    end else begin
      $display("tb_spdif_subframe_decoder_core: done, errors");
    end
    $finish;
  end

endmodule
